>>> src/hashed_bucket_key_set_top_defines.svh
// Assertion macros shared by the hashed bucket key set RTL.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef HASHED_BUCKET_KEY_SET_TOP_DEFINES_SVH
`define HASHED_BUCKET_KEY_SET_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HBKS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define HBKS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/hbks_pkg.sv
// Package for the hashed bucket key set: request kinds, FSM states and defaults.
// No dependencies.
`default_nettype none

package hbks_pkg;

    localparam int BUCKET_BITS_DEF = 10;
    localparam int SLOTS_DEF       = 32;
    localparam int KEY_W           = 32;
    localparam logic [KEY_W-1:0] HASH_MULT_RESET = 32'd1640531527;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_SWEEP_INIT,
        ST_IDLE,
        ST_HASH,
        ST_CNT_RD,
        ST_CNT_WAIT,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef enum logic {
        SWEEP_FROM_RESET,
        SWEEP_FROM_CLEAR
    } sweep_src_t;

endpackage

`default_nettype wire

>>> src/hbks_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module hbks_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> src/hbks_hash.sv
// Multiplicative hash: registered low word of key times multiplier, top bits as bucket.
// Depends on hbks_pkg.
`default_nettype none

module hbks_hash #(
    parameter int BUCKET_BITS = 10
) (
    input  wire logic                     clk,
    input  wire logic [hbks_pkg::KEY_W-1:0] key,
    input  wire logic [hbks_pkg::KEY_W-1:0] multiplier,
    output logic      [BUCKET_BITS-1:0]   bucket
);

    import hbks_pkg::*;

    logic [KEY_W-1:0] prod_reg;
    logic [KEY_W-1:0] prod_next;

    assign prod_next = key * multiplier;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign bucket = prod_reg[KEY_W-1 -: BUCKET_BITS];

endmodule

`default_nettype wire

>>> src/hashed_bucket_key_set_top.sv
// A lookup or add steps through hash, fill-count read, slot scan, update and done; the scan reads
// slots up to a hit or the bucket fill count (at most SLOTS_PER_BUCKET), none for an empty bucket.
// One request at a time; the next can be taken in the cycle after the result is loaded.
// A clear request sweeps the fill-count RAM, zeroing every bucket's count, and then answers.
// After reset the same sweep runs with in_ready low.
// The result register lets the next request in while a result waits.
`default_nettype none

`include "hashed_bucket_key_set_top_defines.svh"

module hashed_bucket_key_set_top #(
    parameter int BUCKET_BITS      = hbks_pkg::BUCKET_BITS_DEF,
    parameter int SLOTS_PER_BUCKET = hbks_pkg::SLOTS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [hbks_pkg::KEY_W-1:0] cfg_wr_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [1:0]                 kind,
    input  wire logic [hbks_pkg::KEY_W-1:0] key,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            present,
    output logic                            inserted,
    output logic                            bucket_full
);

    import hbks_pkg::*;

    localparam int BUCKETS   = 1 << BUCKET_BITS;
    localparam int SLOT_IW   = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int CW        = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int TBL_AW    = BUCKET_BITS + SLOT_IW;
    localparam int TBL_DEPTH = 1 << TBL_AW;

    state_t                 state_reg, state_next;
    sweep_src_t             sweep_src_reg;
    logic [KEY_W-1:0]       mult_reg;
    kind_t                  kind_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [BUCKET_BITS-1:0] sweep_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          rd_idx_reg;
    logic                   pend_reg;
    logic                   found_reg;
    logic                   res_present_reg;
    logic                   res_inserted_reg;
    logic                   res_full_reg;
    logic                   out_valid_reg;
    logic                   present_reg;
    logic                   inserted_reg;
    logic                   full_reg;

    logic [BUCKET_BITS-1:0] bucket;
    logic [CW-1:0]          cnt_rdata;
    logic                   cnt_we;
    logic [BUCKET_BITS-1:0] cnt_waddr;
    logic [CW-1:0]          cnt_wdata;
    logic [KEY_W-1:0]       tbl_rdata;
    logic                   tbl_we;
    logic [TBL_AW-1:0]      tbl_waddr;
    logic [TBL_AW-1:0]      tbl_raddr;

    logic accept;
    logic sweep_last;
    logic hit;
    logic issue;
    logic scan_end;
    logic room;
    logic is_add;
    logic out_load;

    hbks_hash #(
        .BUCKET_BITS(BUCKET_BITS)
    ) u_hash (
        .clk       (clk),
        .key       (key_reg),
        .multiplier(mult_reg),
        .bucket    (bucket)
    );

    hbks_ram #(
        .WIDTH(CW),
        .DEPTH(BUCKETS)
    ) u_cnt_ram (
        .clk  (clk),
        .we   (cnt_we),
        .waddr(cnt_waddr),
        .wdata(cnt_wdata),
        .raddr(bucket),
        .rdata(cnt_rdata)
    );

    hbks_ram #(
        .WIDTH(KEY_W),
        .DEPTH(TBL_DEPTH)
    ) u_tbl_ram (
        .clk  (clk),
        .we   (tbl_we),
        .waddr(tbl_waddr),
        .wdata(key_reg),
        .raddr(tbl_raddr),
        .rdata(tbl_rdata)
    );

    assign accept     = in_valid && in_ready;
    assign sweep_last = &sweep_reg;
    assign hit        = pend_reg && (tbl_rdata == key_reg);
    assign issue      = (state_reg == ST_SCAN) && (rd_idx_reg != count_reg)
                        && !found_reg && !hit;
    assign scan_end   = found_reg || ((rd_idx_reg == count_reg) && !pend_reg);
    assign room       = count_reg < CW'(SLOTS_PER_BUCKET);
    assign is_add     = (kind_reg == KIND_ADD);
    assign tbl_raddr  = {bucket, rd_idx_reg[SLOT_IW-1:0]};
    assign tbl_waddr  = {bucket, count_reg[SLOT_IW-1:0]};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP_INIT:
            begin
                if (sweep_last)
                begin
                    state_next = (sweep_src_reg == SWEEP_FROM_CLEAR) ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind_t'(kind))
                        KIND_LOOKUP: state_next = ST_HASH;
                        KIND_ADD:    state_next = ST_HASH;
                        KIND_CLEAR:  state_next = ST_SWEEP_INIT;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_HASH:     state_next = ST_CNT_RD;
            ST_CNT_RD:   state_next = ST_CNT_WAIT;
            ST_CNT_WAIT: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_load  = 1'b0;
        cnt_we    = 1'b0;
        cnt_waddr = bucket;
        cnt_wdata = count_reg + CW'(1);
        tbl_we    = 1'b0;
        case (state_reg)
            ST_SWEEP_INIT:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = sweep_reg;
                cnt_wdata = '0;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_UPDATE:
            begin
                cnt_we = is_add && !found_reg && room && (key_reg != '0);
                tbl_we = is_add && !found_reg && room && (key_reg != '0);
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP_INIT;
            sweep_src_reg <= SWEEP_FROM_RESET;
            sweep_reg     <= '0;
            mult_reg      <= HASH_MULT_RESET;
            kind_reg      <= KIND_NOP;
            out_valid_reg <= 1'b0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                mult_reg <= cfg_wr_data;
            end
            if (state_reg == ST_SWEEP_INIT)
            begin
                sweep_reg <= sweep_reg + BUCKET_BITS'(1);
            end
            if (accept)
            begin
                kind_reg      <= kind_t'(kind);
                sweep_src_reg <= SWEEP_FROM_CLEAR;
                sweep_reg     <= '0;
            end
            if (state_reg == ST_CNT_WAIT)
            begin
                rd_idx_reg <= '0;
                pend_reg   <= 1'b0;
                found_reg  <= 1'b0;
            end
            else if (state_reg == ST_SCAN)
            begin
                pend_reg  <= issue;
                found_reg <= found_reg || hit;
                if (issue)
                begin
                    rd_idx_reg <= rd_idx_reg + CW'(1);
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg          <= key;
            res_present_reg  <= 1'b0;
            res_inserted_reg <= 1'b0;
            res_full_reg     <= 1'b0;
        end
        if (state_reg == ST_CNT_WAIT)
        begin
            count_reg <= cnt_rdata;
        end
        if (state_reg == ST_UPDATE)
        begin
            res_present_reg  <= found_reg;
            res_inserted_reg <= is_add && !found_reg && room;
            res_full_reg     <= is_add && !found_reg && !room;
        end
        if (out_load)
        begin
            present_reg  <= res_present_reg;
            inserted_reg <= res_inserted_reg;
            full_reg     <= res_full_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign present     = present_reg;
    assign inserted    = inserted_reg;
    assign bucket_full = full_reg;

    `HBKS_ASSERT_NOW(a_one_flag, out_valid_reg,
        $onehot0({present_reg, inserted_reg, full_reg}), "more than one result flag set")
    `HBKS_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready,
        "request accepted while previous still in flight")
    `HBKS_ASSERT_NOW(a_no_zero_store, tbl_we, key_reg != '0,
        "zero key written to slot table")
    `HBKS_ASSERT_NOW(a_fill_bound, cnt_we && (state_reg == ST_UPDATE),
        cnt_wdata <= CW'(SLOTS_PER_BUCKET), "bucket fill count past capacity")

endmodule

`default_nettype wire

>>> sim/hbks_set_checker.sv
`timescale 1ns / 100ps
// Checker for the hashed bucket key set: watches requests and results, predicts each
// result from its own copy of the buckets and the hash multiplier, and counts mismatches.
// Depends on hbks_pkg for the request kinds and the default sizes.

module hbks_set_checker
    import hbks_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [KEY_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [1:0]       kind,
    input  logic [KEY_W-1:0] key,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic             present,
    input  logic             inserted,
    input  logic             bucket_full,
    output int               mismatches,
    output int               pending,
    output int               checked,
    output int               hits,
    output int               stores,
    output int               refusals,
    output int               clears
);

    localparam int BUCKET_COUNT = 1 << BUCKET_BITS_DEF;

    typedef struct packed {
        kind_t            op;
        logic [KEY_W-1:0] k;
        logic             hit;
        logic             stored;
        logic             full;
    } key_result_t;

    logic [KEY_W-1:0] hash_mult;
    logic [KEY_W-1:0] bucket_keys [BUCKET_COUNT][SLOTS_DEF];
    int               bucket_fill [BUCKET_COUNT];
    key_result_t      result_q [$];

    // Slots fill in order and only nonzero keys are ever stored, so a fill count per
    // bucket stands in for the first empty slot.
    function automatic key_result_t apply_set_op(kind_t op, logic [KEY_W-1:0] k);
        key_result_t      r;
        logic [KEY_W-1:0] prod;
        int               b;
        r = '0;
        r.op = op;
        r.k = k;
        case (op)
            KIND_CLEAR:
            begin
                foreach (bucket_fill[j])
                begin
                    bucket_fill[j] = 0;
                end
                clears++;
            end
            KIND_LOOKUP, KIND_ADD:
            begin
                prod = k * hash_mult;
                b = int'(prod >> (KEY_W - BUCKET_BITS_DEF));
                for (int i = 0; i < bucket_fill[b]; i++)
                begin
                    if (bucket_keys[b][i] == k)
                    begin
                        r.hit = 1'b1;
                    end
                end
                if (op == KIND_ADD && !r.hit)
                begin
                    if (bucket_fill[b] < SLOTS_DEF)
                    begin
                        r.stored = 1'b1;
                        if (k != '0)
                        begin
                            bucket_keys[b][bucket_fill[b]] = k;
                            bucket_fill[b]++;
                        end
                    end
                    else
                    begin
                        r.full = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, key_result_t want, logic p, logic i, logic f);
        mismatches++;
        if (mismatches <= 40)
        begin
            $display("%0t: %s for %s key %h: expected present/inserted/full %b%b%b, got %b%b%b",
                     $time, what, want.op.name(), want.k, want.hit, want.stored, want.full,
                     p, i, f);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        key_result_t want;
        if (!rst_n)
        begin
            hash_mult = HASH_MULT_RESET;
            foreach (bucket_fill[j])
            begin
                bucket_fill[j] = 0;
            end
            result_q.delete();
            pending = 0;
            checked = 0;
            hits = 0;
            stores = 0;
            refusals = 0;
            clears = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                hash_mult = cfg_wr_data;
            end
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                begin
                    report_mismatch("result with no request waiting", '0, present, inserted,
                                    bucket_full);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (present !== want.hit)
                    begin
                        report_mismatch("present differs", want, present, inserted, bucket_full);
                    end
                    if (inserted !== want.stored)
                    begin
                        report_mismatch("inserted differs", want, present, inserted, bucket_full);
                    end
                    if (bucket_full !== want.full)
                    begin
                        report_mismatch("bucket_full differs", want, present, inserted,
                                        bucket_full);
                    end
                    checked++;
                    hits += int'(want.hit);
                    stores += int'(want.stored);
                    refusals += int'(want.full);
                end
            end
            if (in_valid && in_ready)
            begin
                result_q.push_back(apply_set_op(kind_t'(kind), key));
            end
            pending = result_q.size();
        end
    end

endmodule

>>> sim/hashed_bucket_key_set_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the hashed bucket key set: drives requests and the hash multiplier
// through several settings, with random idling on both sides, and gives the verdict.
// Depends on hbks_pkg, hashed_bucket_key_set_top and hbks_set_checker.

module hashed_bucket_key_set_top_tb
    import hbks_pkg::*;
;

    localparam int NUM_MULTS       = 7;
    localparam int ITEMS_PER_PHASE = 276;
    localparam int HOT_BUCKETS     = 3;
    localparam int SETTLE          = SLOTS_DEF + 8;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [KEY_W-1:0] cfg_wr_data;
    logic             in_valid;
    logic             in_ready;
    kind_t            kind;
    logic [KEY_W-1:0] key;
    logic             out_valid;
    logic             out_ready;
    logic             present;
    logic             inserted;
    logic             bucket_full;

    int mismatches;
    int pending;
    int checked;
    int hits;
    int stores;
    int refusals;
    int clears;

    bit                          calm;
    int                          sent;
    int                          mult_writes;
    logic [KEY_W-1:0]            cur_mult;
    logic [KEY_W-1:0]            known_keys [$];
    logic [KEY_W-1:0]            corner_keys [5];
    logic [BUCKET_BITS_DEF-1:0]  hot [HOT_BUCKETS];

    hashed_bucket_key_set_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .key         (key),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .present     (present),
        .inserted    (inserted),
        .bucket_full (bucket_full)
    );

    hbks_set_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .key         (key),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .present     (present),
        .inserted    (inserted),
        .bucket_full (bucket_full),
        .mismatches  (mismatches),
        .pending     (pending),
        .checked     (checked),
        .hits        (hits),
        .stores      (stores),
        .refusals    (refusals),
        .clears      (clears)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [BUCKET_BITS_DEF-1:0] bucket_index(logic [KEY_W-1:0] k,
                                                                logic [KEY_W-1:0] m);
        logic [KEY_W-1:0] prod;
        prod = k * m;
        return prod[KEY_W-1 -: BUCKET_BITS_DEF];
    endfunction

    // Keys that land in one of the hot buckets, so that buckets fill up and overflow.
    // An odd multiplier is inverted modulo 2**32; otherwise random keys are tried.
    function automatic logic [KEY_W-1:0] crowded_key(logic [KEY_W-1:0] m);
        logic [KEY_W-1:0]           inv;
        logic [KEY_W-1:0]           cand;
        logic [KEY_W-BUCKET_BITS_DEF-1:0] low;
        logic [BUCKET_BITS_DEF-1:0] hb;
        hb = hot[$urandom_range(HOT_BUCKETS - 1)];
        if (m[0])
        begin
            inv = m;
            repeat (5) inv = inv * (32'd2 - m * inv);
            low = (KEY_W - BUCKET_BITS_DEF)'($urandom);
            return {hb, low} * inv;
        end
        cand = $urandom;
        repeat (4096)
        begin
            if (bucket_index(cand, m) == hb)
            begin
                return cand;
            end
            cand = $urandom;
        end
        return cand;
    endfunction

    task automatic send_request(input kind_t op, input logic [KEY_W-1:0] k);
        while (!calm && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= op;
        key <= k;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        sent++;
        @(negedge clk);
    endtask

    task automatic set_multiplier(input logic [KEY_W-1:0] m);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cur_mult = m;
        mult_writes++;
    endtask

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            out_ready <= calm || ($urandom_range(99) >= 7);
        end
    end

    initial
    begin
        logic [KEY_W-1:0] mults [NUM_MULTS];
        logic [KEY_W-1:0] k;
        kind_t            op;
        int               r;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        kind = KIND_LOOKUP;
        key = '0;
        calm = 1'b0;
        sent = 0;
        mult_writes = 0;
        cur_mult = HASH_MULT_RESET;
        corner_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                        32'h7FFF_FFFF};
        mults = '{HASH_MULT_RESET, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                  32'h0040_0000, $urandom | 32'd1, $urandom};
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        while (!in_ready)
        begin
            @(negedge clk);
        end

        send_request(KIND_LOOKUP, 32'h0000_0000);
        send_request(KIND_ADD, 32'h0000_0000);
        send_request(KIND_LOOKUP, 32'h0000_0000);
        send_request(KIND_ADD, 32'hFFFF_FFFF);
        send_request(KIND_ADD, 32'hFFFF_FFFF);
        send_request(KIND_LOOKUP, 32'hFFFF_FFFF);
        send_request(KIND_ADD, 32'h0000_0001);
        send_request(KIND_LOOKUP, 32'h0000_0001);
        send_request(KIND_ADD, 32'h8000_0000);
        send_request(KIND_LOOKUP, 32'h7FFF_FFFF);
        send_request(KIND_NOP, 32'hFFFF_FFFF);
        send_request(KIND_NOP, 32'h0000_0000);
        send_request(KIND_CLEAR, $urandom);
        send_request(KIND_LOOKUP, 32'hFFFF_FFFF);
        send_request(KIND_ADD, 32'h8000_0000);
        in_valid <= 1'b0;

        for (int ph = 0; ph < NUM_MULTS; ph++)
        begin
            set_multiplier(mults[ph]);
            calm = (ph == 3);
            known_keys.delete();
            for (int h = 0; h < HOT_BUCKETS; h++)
            begin
                hot[h] = bucket_index($urandom, cur_mult);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                r = $urandom_range(99);
                if (r < 35)
                begin
                    k = crowded_key(cur_mult);
                end
                else if (r < 65 && known_keys.size() > 0)
                begin
                    k = known_keys[$urandom_range(known_keys.size() - 1)];
                end
                else if (r < 72)
                begin
                    k = corner_keys[$urandom_range(4)];
                end
                else
                begin
                    k = $urandom;
                end
                r = $urandom_range(99);
                if (r < 40)
                begin
                    op = KIND_LOOKUP;
                end
                else if (r < 96)
                begin
                    op = KIND_ADD;
                end
                else if (r < 99)
                begin
                    op = KIND_NOP;
                end
                else
                begin
                    op = KIND_CLEAR;
                end
                send_request(op, k);
                if (op == KIND_ADD)
                begin
                    known_keys.push_back(k);
                    if (known_keys.size() > 64)
                    begin
                        void'(known_keys.pop_front());
                    end
                end
            end
            in_valid <= 1'b0;
        end

        calm = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
        $display("Sent %0d requests under %0d hash multiplier settings, %0d of them clears.",
                 sent, mult_writes + 1, clears);
        $display("Checked %0d results: %0d hits, %0d stores, %0d full-bucket refusals.",
                 checked, hits, stores, refusals);
        if (mismatches == 0 && pending == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Timed out with %0d results still outstanding.", pending);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
